[hw/rtl/smsd_pkg.sv]
// Shared types and constants for the sensor matrix scan debouncer.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package smsd_pkg;

  localparam int unsigned GroupCountDef = 8;
  localparam int unsigned Channels      = 16;
  localparam int unsigned ChanW         = $clog2(Channels);
  localparam int unsigned StreakW       = 8;

  localparam logic [Channels-1:0] FullMap     = '1;
  localparam logic [StreakW-1:0]  ThreshReset = 8'd3;
  localparam logic [StreakW-1:0]  StreakMax   = '1;

  typedef logic [Channels-1:0] map_t;

  // Result kinds as they appear on the output.
  typedef enum logic [1:0] {
    KindSummary = 2'd0,
    KindRemoved = 2'd1,
    KindAdded   = 2'd2,
    KindError   = 2'd3
  } kind_e;

  // What the last accepted item asks the sequencer to report.
  typedef enum logic [1:0] {
    EvtNone  = 2'd0,
    EvtFrame = 2'd1,
    EvtError = 2'd2
  } evt_e;

  typedef struct packed {
    logic [2:0] group_index;
    logic [7:0] port0_byte;
    logic [7:0] port1_byte;
    logic       read_failed;
  } in_item_t;

  typedef struct packed {
    kind_e              kind;
    map_t               raw_map;
    map_t               stable_map;
    logic [StreakW-1:0] streak_count;
    logic [ChanW-1:0]   run_first;
    logic [ChanW-1:0]   run_final;
    logic               last_of_run;
  } out_item_t;

  typedef struct packed {
    evt_e               evt;
    map_t               raw_map;
    map_t               stable_map;
    logic [StreakW-1:0] streak;
    map_t               removed;
    map_t               added;
  } frame_stat_t;

  typedef struct packed {
    logic start;
    map_t removed;
    map_t added;
  } walk_ctrl_t;

  typedef struct packed {
    logic             busy;
    logic             run_valid;
    kind_e            kind;
    logic [ChanW-1:0] run_first;
    logic [ChanW-1:0] run_final;
    logic             last;
  } walk_stat_t;

endpackage

`default_nettype wire

[hw/rtl/smsd_frame.sv]
// Frame accumulation and debounce state of the scan debouncer.
// Depends on smsd_pkg.
`default_nettype none

module smsd_frame #(
  parameter int unsigned GroupCount = smsd_pkg::GroupCountDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  smsd_pkg::in_item_t    item_i,
  input  logic [7:0]            threshold_i,
  output smsd_pkg::frame_stat_t stat_o
);
  import smsd_pkg::*;

  localparam logic [3:0] GroupLimit = 4'(GroupCount);
  localparam logic [2:0] LastGroup  = 3'(GroupCount - 1);

  map_t               acc_q, acc_d, prev_q, prev_d, stable_q, stable_d;
  map_t               raw_q, raw_d, removed_q, removed_d, added_q, added_d;
  logic [StreakW-1:0] count_q, count_d;
  evt_e               evt_q, evt_d;
  map_t               hit, acc_new;
  logic [2:0]         grp;

  assign grp = item_i.group_index;

  always_comb begin
    hit                  = '0;
    hit[{1'b0, grp}]     = ~item_i.port0_byte[grp];
    hit[{1'b1, grp}]     = ~item_i.port1_byte[grp];
    acc_new              = ((grp == 3'd0) ? '0 : acc_q) | hit;

    acc_d     = acc_q;
    prev_d    = prev_q;
    stable_d  = stable_q;
    count_d   = count_q;
    evt_d     = evt_q;
    raw_d     = raw_q;
    removed_d = removed_q;
    added_d   = added_q;

    if (accept_i) begin
      if (item_i.read_failed) begin
        acc_d = '0;
        evt_d = EvtError;
      end else if ({1'b0, grp} >= GroupLimit) begin
        evt_d = EvtNone;
      end else begin
        acc_d = acc_new;
        evt_d = EvtNone;
        if (grp == LastGroup) begin
          evt_d = EvtFrame;
          raw_d = acc_new;
          if (acc_new == prev_q) begin
            count_d = (count_q == StreakMax) ? count_q : count_q + 8'd1;
          end else begin
            prev_d  = acc_new;
            count_d = 8'd1;
          end
          // A threshold of zero is met just like one, since the streak is at least one here.
          stable_d  = (count_d >= threshold_i) ? acc_new : stable_q;
          removed_d = stable_q & ~stable_d;
          added_d   = stable_d & ~stable_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q    <= '0;
      prev_q   <= FullMap;
      stable_q <= FullMap;
      count_q  <= '0;
      evt_q    <= EvtNone;
    end else begin
      acc_q    <= acc_d;
      prev_q   <= prev_d;
      stable_q <= stable_d;
      count_q  <= count_d;
      evt_q    <= evt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    raw_q     <= raw_d;
    removed_q <= removed_d;
    added_q   <= added_d;
  end

  assign stat_o.evt        = evt_q;
  assign stat_o.raw_map    = raw_q;
  assign stat_o.stable_map = stable_q;
  assign stat_o.streak     = count_q;
  assign stat_o.removed    = removed_q;
  assign stat_o.added      = added_q;

endmodule

`default_nettype wire

[hw/rtl/smsd_run_walk.sv]
// Run walker: shifts a change mask one channel per cycle and reports contiguous runs;
// a run end waiting for a stalled output holds the shift. Depends on smsd_pkg.
`default_nettype none

module smsd_run_walk (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  smsd_pkg::walk_ctrl_t ctrl_i,
  input  logic                 out_free_i,
  output smsd_pkg::walk_stat_t stat_o
);
  import smsd_pkg::*;

  logic               busy_q, busy_d, open_q, open_d;
  kind_e              kind_q, kind_d;
  map_t               mask_q, mask_d, added_q, added_d;
  logic [ChanW:0]     ch_q, ch_d;
  logic [ChanW-1:0]   first_q, first_d;
  logic               bit_now, close, phase_end;

  // The mask is shifted as the walk goes, so bit 0 is always the current channel.
  assign bit_now   = mask_q[0];
  assign close     = busy_q && open_q && !bit_now;
  assign phase_end = busy_q && !open_q && (mask_q == '0);

  always_comb begin
    busy_d  = busy_q;
    open_d  = open_q;
    kind_d  = kind_q;
    mask_d  = mask_q;
    added_d = added_q;
    ch_d    = ch_q;
    first_d = first_q;

    if (ctrl_i.start) begin
      busy_d  = 1'b1;
      open_d  = 1'b0;
      kind_d  = KindRemoved;
      mask_d  = ctrl_i.removed;
      added_d = ctrl_i.added;
      ch_d    = '0;
    end else if (phase_end) begin
      if (kind_q == KindRemoved && added_q != '0) begin
        kind_d = KindAdded;
        mask_d = added_q;
        ch_d   = '0;
      end else begin
        busy_d = 1'b0;
      end
    end else if (busy_q && (!close || out_free_i)) begin
      mask_d = mask_q >> 1;
      ch_d   = ch_q + 1'b1;
      if (bit_now && !open_q) begin
        open_d  = 1'b1;
        first_d = ch_q[ChanW-1:0];
      end else if (close) begin
        open_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      open_q  <= 1'b0;
      kind_q  <= KindRemoved;
      mask_q  <= '0;
      added_q <= '0;
      ch_q    <= '0;
    end else begin
      busy_q  <= busy_d;
      open_q  <= open_d;
      kind_q  <= kind_d;
      mask_q  <= mask_d;
      added_q <= added_d;
      ch_q    <= ch_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q <= first_d;
  end

  assign stat_o.busy      = busy_q;
  assign stat_o.run_valid = close;
  assign stat_o.kind      = kind_q;
  assign stat_o.run_first = first_q;
  assign stat_o.run_final = ChanW'(ch_q - 1'b1);
  assign stat_o.last      = (mask_q == '0) && (kind_q == KindAdded || added_q == '0);

endmodule

`default_nettype wire

[hw/rtl/sensor_matrix_scan_debounce.sv]
// Top level of the sensor matrix scan debouncer: sequencer and output register.
// Depends on smsd_pkg, smsd_frame and smsd_run_walk.
//
//   Port group     Direction  Handshake            Content
//   cfg_*          in         cfg_we_i             stable_threshold
//   in_*           in         in_valid_i/in_stall_o  one scan group read
//   out_*          out        out_valid_o/out_stall_i  summary, run or error item
//
// A group that does not complete a frame, and an ignored group, pass from idle
// through evaluation back to idle. A read error or a frame with an unchanged
// stable map also passes the head state, which waits out any output stall. A
// frame that changes the stable map adds the run walker: it steps through each
// nonempty mask up to its highest changed channel, closes its last run and moves
// on, passes over an empty mask, and then leaves the walk.
// Reset puts the debounce state at its documented values at once; there is no
// clearing pass. A stalled output holds the walker, and the next item is taken
// while the final result of the previous one still waits in the output register.
`default_nettype none

module sensor_matrix_scan_debounce #(
  parameter int unsigned GroupCount = smsd_pkg::GroupCountDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  smsd_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output smsd_pkg::out_item_t out_item_o
);
  import smsd_pkg::*;

  // Sequencer states, one-hot.
  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StEval = 4'b0010,
    StHead = 4'b0100,
    StWalk = 4'b1000
  } state_e;

  state_e      state_q, state_d;
  logic [7:0]  thresh_q;
  logic        accept, out_free, load, changes;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_q, out_d;
  frame_stat_t frame;
  walk_ctrl_t  walk_ctrl;
  walk_stat_t  walk;

  // Threshold register; user writes it only while the block is idle (unchecked).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= ThreshReset;
    end else if (cfg_we_i) begin
      thresh_q <= cfg_wdata_i;
    end
  end

  // Items are taken only when the sequencer is idle.
  assign in_stall_o = (state_q != StIdle);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign changes    = (frame.removed | frame.added) != '0;

  smsd_frame #(
    .GroupCount (GroupCount)
  ) u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .item_i      (in_item_i),
    .threshold_i (thresh_q),
    .stat_o      (frame)
  );

  // The walker starts when the summary leaves and the stable map changed.
  assign walk_ctrl.start   = (state_q == StHead) && out_free && (frame.evt == EvtFrame)
                             && changes;
  assign walk_ctrl.removed = frame.removed;
  assign walk_ctrl.added   = frame.added;

  smsd_run_walk u_walk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (walk_ctrl),
    .out_free_i (out_free),
    .stat_o     (walk)
  );

  always_comb begin
    state_d = state_q;
    load    = 1'b0;
    out_d   = out_q;

    case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StEval;
        end
      end
      StEval: begin
        // The frame unit has now settled what the accepted item reports.
        case (frame.evt)
          EvtFrame, EvtError: state_d = StHead;
          default:            state_d = StIdle;
        endcase
      end
      StHead: begin
        if (out_free) begin
          load               = 1'b1;
          out_d.stable_map   = frame.stable_map;
          out_d.streak_count = frame.streak;
          out_d.run_first    = '0;
          out_d.run_final    = '0;
          if (frame.evt == EvtError) begin
            out_d.kind        = KindError;
            out_d.raw_map     = '0;
            out_d.last_of_run = 1'b1;
            state_d           = StIdle;
          end else begin
            out_d.kind        = KindSummary;
            out_d.raw_map     = frame.raw_map;
            out_d.last_of_run = !changes;
            state_d           = changes ? StWalk : StIdle;
          end
        end
      end
      StWalk: begin
        if (walk.run_valid && out_free) begin
          load               = 1'b1;
          out_d.kind         = walk.kind;
          out_d.raw_map      = frame.raw_map;
          out_d.stable_map   = frame.stable_map;
          out_d.streak_count = frame.streak;
          out_d.run_first    = walk.run_first;
          out_d.run_final    = walk.run_final;
          out_d.last_of_run  = walk.last;
        end
        if (!walk.busy) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // A free output register either loads a new item or empties.
  assign out_valid_d = out_free ? load : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

[hw/rtl/smsd_checker.sv]
// Port-level checks for the sensor matrix scan debouncer, bound to its top level.
// Depends on smsd_pkg and sensor_matrix_scan_debounce.
`default_nettype none

module smsd_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input smsd_pkg::out_item_t out_item_o
);
  import smsd_pkg::*;

  // A stalled output item must hold.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled output item changed");

  // An accepted item keeps the input side closed for at least the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again right after an item");

  // An error item stands alone and carries an empty raw map.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.kind == KindError |->
      out_item_o.last_of_run && out_item_o.raw_map == '0)
    else $error("malformed error item");

  // Summaries carry no run; runs are ascending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (out_item_o.kind == KindSummary && out_item_o.run_first == '0
        && out_item_o.run_final == '0)
      || ((out_item_o.kind == KindRemoved || out_item_o.kind == KindAdded)
        && out_item_o.run_first <= out_item_o.run_final)
      || out_item_o.kind == KindError)
    else $error("bad run fields");

  // While a frame still has results to come, no new item may be taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.last_of_run |-> in_stall_o)
    else $error("input open in the middle of a frame report");

endmodule

bind sensor_matrix_scan_debounce smsd_checker u_smsd_checker (.*);

`default_nettype wire

[tb/smsd_scan_checker.sv]
`timescale 1ns / 100ps
// Result checker for the sensor matrix scan debouncer: predicts every report
// from the accepted group reads and compares it with what the block emits.
// Depends on smsd_pkg for the item types and result kinds.

module smsd_scan_checker
  import smsd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_item_t  in_item_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_item_t out_item_i,
  output int        fail_count_o,
  output int        pending_o
);

  localparam int ShownFailures = 10;

  // Shadow copy of the debounce state and the threshold register.
  logic [7:0]         thresh;
  map_t               acc_map;
  map_t               prev_map;
  map_t               stable_map;
  logic [StreakW-1:0] streak;

  out_item_t due_reports[$];

  task automatic queue_change_runs(input kind_e kind, input map_t raw, input map_t bits);
    out_item_t rec;
    int        start;
    int        stop;
    bit        run_open;
    bit        bit_on;
    run_open = 1'b0;
    start = 0;
    for (int ch = 0; ch <= Channels; ch++) begin
      bit_on = 1'b0;
      if (ch < Channels) bit_on = bits[ch];
      if (bit_on && !run_open) begin
        run_open = 1'b1;
        start = ch;
      end else if (!bit_on && run_open) begin
        stop = ch - 1;
        rec = '0;
        rec.kind = kind;
        rec.raw_map = raw;
        rec.stable_map = stable_map;
        rec.streak_count = streak;
        rec.run_first = start[ChanW-1:0];
        rec.run_final = stop[ChanW-1:0];
        due_reports.push_back(rec);
        run_open = 1'b0;
      end
    end
  endtask

  task automatic fold_group_read(input in_item_t it);
    out_item_t rec;
    map_t      frame;
    map_t      prior;
    int        g;
    g = it.group_index;
    rec = '0;
    if (it.read_failed) begin
      // A failed read throws away the partial frame and reports an error.
      acc_map = '0;
      rec.kind = KindError;
      rec.stable_map = stable_map;
      rec.streak_count = streak;
      rec.last_of_run = 1'b1;
      due_reports.push_back(rec);
    end else if (g < GroupCountDef) begin
      if (g == 0) acc_map = '0;
      if (!it.port0_byte[g]) acc_map[g] = 1'b1;
      if (!it.port1_byte[g]) acc_map[g + 8] = 1'b1;
      if (g == GroupCountDef - 1) begin
        frame = acc_map;
        if (frame == prev_map) begin
          if (streak != StreakMax) streak = streak + 1'b1;
        end else begin
          prev_map = frame;
          streak = 8'd1;
        end
        prior = stable_map;
        if (streak >= thresh) stable_map = frame;
        rec.kind = KindSummary;
        rec.raw_map = frame;
        rec.stable_map = stable_map;
        rec.streak_count = streak;
        due_reports.push_back(rec);
        queue_change_runs(KindRemoved, frame, prior & ~stable_map);
        queue_change_runs(KindAdded, frame, stable_map & ~prior);
        rec = due_reports.pop_back();
        rec.last_of_run = 1'b1;
        due_reports.push_back(rec);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      thresh = ThreshReset;
      acc_map = '0;
      prev_map = FullMap;
      stable_map = FullMap;
      streak = '0;
      due_reports.delete();
      fail_count_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (due_reports.size() == 0) begin
          if (fail_count_o < ShownFailures)
            $display("%0t: unexpected result kind %0d raw %h stable %h streak %0d run %0d..%0d last %b",
                     $time, out_item_i.kind, out_item_i.raw_map, out_item_i.stable_map,
                     out_item_i.streak_count, out_item_i.run_first, out_item_i.run_final,
                     out_item_i.last_of_run);
          fail_count_o++;
        end else begin
          want = due_reports.pop_front();
          if (out_item_i.kind !== want.kind || out_item_i.raw_map !== want.raw_map ||
              out_item_i.stable_map !== want.stable_map ||
              out_item_i.streak_count !== want.streak_count ||
              out_item_i.run_first !== want.run_first ||
              out_item_i.run_final !== want.run_final ||
              out_item_i.last_of_run !== want.last_of_run) begin
            if (fail_count_o < ShownFailures) begin
              $display("%0t: result differs, expected kind %0d raw %h stable %h streak %0d run %0d..%0d last %b",
                       $time, want.kind, want.raw_map, want.stable_map, want.streak_count,
                       want.run_first, want.run_final, want.last_of_run);
              $display("%0t:                     got kind %0d raw %h stable %h streak %0d run %0d..%0d last %b",
                       $time, out_item_i.kind, out_item_i.raw_map, out_item_i.stable_map,
                       out_item_i.streak_count, out_item_i.run_first, out_item_i.run_final,
                       out_item_i.last_of_run);
            end
            fail_count_o++;
          end
        end
      end
      if (cfg_we_i) thresh = cfg_wdata_i;
      if (in_valid_i && !in_stall_i) fold_group_read(in_item_i);
    end
    pending_o = due_reports.size();
  end

endmodule

[tb/sensor_matrix_scan_debounce_tb.sv]
`timescale 1ns / 100ps
// Top of the scan debouncer testbench: clock, reset, group read stimulus and verdict.
// Depends on smsd_pkg, the block itself and smsd_scan_checker.

module sensor_matrix_scan_debounce_tb;
  import smsd_pkg::*;

  // Quiet cycles after the last report; plenty for a frame that changes the
  // stable map to finish its work.
  localparam int SettleCycles = 60;
  // The receiver holds off this long once, so the block backs up into the sender.
  localparam int HoldCycles   = 300;
  // A generous bound for roughly 260 items, plus hold-off and settling.
  localparam int CycleLimit   = 500000;
  localparam int IdlePercent  = 13;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      cfg_we    = 1'b0;
  logic [7:0] cfg_wdata = ThreshReset;
  logic      in_valid  = 1'b0;
  in_item_t  in_item   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_item;

  int fail_count;
  int pending;

  // Idle controls for both sides and the hold-off request counter.
  bit tx_idle_en  = 1'b1;
  bit rx_idle_en  = 1'b1;
  int hold_asks   = 0;
  int hold_served = 0;
  int hold_left   = 0;
  int items_sent  = 0;
  int cycles      = 0;

  always #5 clk = ~clk;

  sensor_matrix_scan_debounce uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  smsd_scan_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_item_i   (out_item),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Receiver side. A new hold-off request starts a long stall that is counted
  // down here; otherwise the receiver stalls at random when idling is enabled.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      hold_served <= 0;
    end else if (hold_served != hold_asks) begin
      hold_served <= hold_asks;
      hold_left <= HoldCycles;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= rx_idle_en && ($urandom_range(0, 99) < IdlePercent);
    end
  end

  // Watchdog: a hung block or a lost report ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Offers one item, starting at a rising edge and returning at the edge that
  // accepts it. Idle gaps go in front of the item, never while it is offered,
  // so the payload stays put for as long as the block stalls it. The stall is
  // looked at on the falling edge, where it is settled.
  task automatic offer_read(input in_item_t it);
    if (tx_idle_en) begin
      while ($urandom_range(0, 99) < IdlePercent) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    items_sent++;
  endtask

  // One group read. The bit at the group position in each byte carries the
  // wanted map bit (active low); every other bit is random, since the block
  // must ignore it.
  task automatic send_group(input int g, input map_t m, input bit fail);
    in_item_t it;
    it.group_index = g[2:0];
    it.port0_byte = 8'($urandom);
    it.port1_byte = 8'($urandom);
    it.port0_byte[g] = ~m[g];
    it.port1_byte[g] = ~m[g + 8];
    it.read_failed = fail;
    offer_read(it);
  endtask

  // A well-formed frame: group 0 clears the accumulator, the middle groups come
  // in shuffled order, and the last group completes it. A sparse frame skips
  // the middle groups that carry no blocked channel.
  task automatic send_frame(input map_t m, input bit dense);
    int order[6];
    int j;
    int tmp;
    for (int i = 0; i < 6; i++) order[i] = i + 1;
    for (int i = 5; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    send_group(0, m, 1'b0);
    for (int i = 0; i < 6; i++)
      if (dense || m[order[i]] || m[order[i] + 8]) send_group(order[i], m, 1'b0);
    send_group(GroupCountDef - 1, m, 1'b0);
  endtask

  // Stops offering and waits until every predicted report has arrived, then
  // lets the block finish any work that produces nothing more. Returns on a
  // rising edge.
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // The threshold is only written while the block is idle.
  task automatic write_threshold(input logic [7:0] value);
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly frames whose map repeats often enough to pass the threshold, with
  // aborted frames and stray reads mixed in.
  task automatic random_burst(input int goal);
    map_t     scene;
    in_item_t stray;
    int       roll;
    scene = map_t'($urandom);
    while (items_sent < goal) begin
      roll = $urandom_range(0, 99);
      if (roll < 72) begin
        if ($urandom_range(0, 3) == 0) begin
          case ($urandom_range(0, 3))
            0: scene = map_t'($urandom);
            1: scene = scene ^ (map_t'(1) << $urandom_range(0, 15));
            2: scene = ~scene;
            default: scene = ($urandom_range(0, 1) != 0) ? 16'h5555 : 16'haaaa;
          endcase
        end
        send_frame(scene, $urandom_range(0, 2) != 0);
      end else if (roll < 86) begin
        // A frame that is started and then broken off, by a read error or
        // simply by the next frame restarting at group 0.
        send_group(0, map_t'($urandom), 1'b0);
        repeat ($urandom_range(0, 4))
          send_group($urandom_range(1, 6), map_t'($urandom), 1'b0);
        if ($urandom_range(0, 1) != 0)
          send_group($urandom_range(0, 7), map_t'($urandom), 1'b1);
      end else begin
        stray = in_item_t'($urandom);
        stray.read_failed = ($urandom_range(0, 3) == 0);
        offer_read(stray);
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, reset threshold of 3. A read error right after reset
    // reports the all-blocked stable map and a zero streak.
    send_group(3, 16'h0000, 1'b1);
    // An all-blocked frame matches the reset previous frame; two more repeats
    // reach the threshold without changing the stable map, so only summaries.
    send_frame(FullMap, 1'b1);
    send_group(7, FullMap, 1'b0);
    send_group(7, FullMap, 1'b0);
    // An all-clear frame repeated three times removes every channel in one run.
    send_group(0, 16'h0000, 1'b0);
    send_group(7, 16'h0000, 1'b0);
    send_group(7, 16'h0000, 1'b0);
    send_group(7, 16'h0000, 1'b0);
    // A read error in the middle of a frame wipes what was gathered so far.
    send_group(0, FullMap, 1'b0);
    send_group(4, FullMap, 1'b1);
    send_group(7, 16'h0000, 1'b0);

    // Threshold 1: alternating maps give the most runs per frame, up to eight
    // removed and eight added runs after the summary.
    write_threshold(8'd1);
    send_frame(16'h5555, 1'b0);
    send_frame(16'haaaa, 1'b0);

    // Threshold 0 behaves like 1. While the receiver holds off, the sender
    // keeps offering run-heavy frames so the block backs up and stalls.
    write_threshold(8'd0);
    send_frame(16'h8001, 1'b0);
    hold_asks <= hold_asks + 1;
    repeat (3) begin
      send_frame(16'h5555, 1'b0);
      send_frame(16'haaaa, 1'b0);
    end

    // Random part, one phase per threshold. The second phase runs without any
    // idling on either side.
    write_threshold(8'd2);
    random_burst(items_sent + 50);
    write_threshold(8'd1);
    tx_idle_en = 1'b0;
    rx_idle_en <= 1'b0;
    random_burst(items_sent + 50);
    write_threshold(8'd4);
    tx_idle_en = 1'b1;
    rx_idle_en <= 1'b1;
    random_burst(items_sent + 50);
    write_threshold(8'd0);
    random_burst(items_sent + 50);

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
